FILE: sv/fpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg - shared types and constants of the q24.8 fixed-point alu
// operation codes, pipeline side-band record and divider stage geometry
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FRAC_BITS_DEF      = 8;
    localparam int DIV_BITS_PER_STAGE = 4;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_LT       = 4'd4,
        OP_GT       = 4'd5,
        OP_LE       = 4'd6,
        OP_GE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_TO_INT   = 4'd14,
        OP_FROM_INT = 4'd15
    } t_op;

    // which unit supplies the final result
    typedef enum logic [1:0] {
        SEL_SIMPLE = 2'd0,
        SEL_MUL    = 2'd1,
        SEL_DIV    = 2'd2
    } t_sel;

    typedef struct packed {
        logic [31:0] res;
        logic        flag;
        t_sel        sel;
        logic        neg;
    } t_side;

endpackage

FILE: sv/fpa_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_div_pipe - pipelined unsigned restoring divider
// four quotient bits per stage, low 32 quotient bits kept, one word per cycle while i_en is high
// ----------------------------------------------------------------------------
module fpa_div_pipe #(
    parameter int NSTG  = 10,
    parameter int DVD_W = 40
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DVD_W-1:0]  i_dvd,
    input  logic [31:0]       i_dvs,
    output logic [31:0]       o_quo
);
    import fpa_pkg::*;

    logic [31:0]      r_rem [NSTG];
    logic [DVD_W-1:0] r_dvd [NSTG];
    logic [31:0]      r_quo [NSTG];
    logic [31:0]      r_dvs [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic [31:0]      src_rem;
        logic [DVD_W-1:0] src_dvd;
        logic [31:0]      src_quo;
        logic [31:0]      src_dvs;
        logic [31:0]      n_rem;
        logic [DVD_W-1:0] n_dvd;
        logic [31:0]      n_quo;

        if (s == 0) begin : g_first
            assign src_rem = '0;
            assign src_dvd = i_dvd;
            assign src_quo = '0;
            assign src_dvs = i_dvs;
        end else begin : g_next
            assign src_rem = r_rem[s-1];
            assign src_dvd = r_dvd[s-1];
            assign src_quo = r_quo[s-1];
            assign src_dvs = r_dvs[s-1];
        end

        always_comb begin
            logic [32:0] trial;
            n_rem = src_rem;
            n_dvd = src_dvd;
            n_quo = src_quo;
            for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
                trial = {n_rem, n_dvd[DVD_W-1]};
                n_dvd = {n_dvd[DVD_W-2:0], 1'b0};
                if (trial >= {1'b0, src_dvs}) begin
                    n_rem = 32'(trial - {1'b0, src_dvs});
                    n_quo = {n_quo[30:0], 1'b1};
                end else begin
                    n_rem = trial[31:0];
                    n_quo = {n_quo[30:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_dvd[s] <= n_dvd;
                r_quo[s] <= n_quo;
                r_dvs[s] <= src_dvs;
            end
        end
    end

    assign o_quo = r_quo[NSTG-1];

endmodule

FILE: sv/fixed_point_q24_8_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu - pipelined signed q24.8 fixed-point alu
// add, sub, mul, div, compares, min/max, inc/dec and integer conversions
// ----------------------------------------------------------------------------
// usage:
//   slave channel: one word per operation, tdata = {operand_b, operand_a},
//   tuser = op. master channel: tdata = result, tuser = flag.
//   results pass through the stage-1 registers, the divider stages and the
//   output register; the divider retires four quotient bits per stage; all
//   operations share that pipe so results leave in input order.
//   throughput is one word per cycle unless the receiver stalls; the
//   multiplier is one 32x32 product registered in the first stage.
//   when the receiver stalls with a result waiting, the whole pipe holds and
//   o_s_tready drops; nothing is lost or repeated. reset clears the valid
//   bits only, so the pipe comes up empty.
//   comparisons give raw one (2^FRAC_BITS) and flag on true; divide by zero
//   gives zero with flag set.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // operand_a [31:0], operand_b [63:32]
    input  logic [3:0]  i_s_tuser,   // op [3:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // result [31:0]
    output logic [0:0]  o_m_tuser    // flag [0]
);
    import fpa_pkg::*;

    localparam int DVD_BITS = 32 + FRAC_BITS;
    localparam int NDIV     = (DVD_BITS + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
    localparam int DVD_W    = NDIV * DIV_BITS_PER_STAGE;
    localparam logic [31:0] ONE     = 32'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS+31:0] MUL_BIAS = (FRAC_BITS+32)'((1 << FRAC_BITS) - 1);

    // global advance: the pipe moves unless the output word is stuck
    logic en;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // ---------------- stage 1: decode, simple ops, multiply, divider prep
    t_op                op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               lt;
    logic               eq;
    logic               cmp;
    t_side              n_side0;
    logic [31:0]        abs_a;
    logic [31:0]        abs_b;

    assign op    = t_op'(i_s_tuser);
    assign a     = $signed(i_s_tdata[31:0]);
    assign b     = $signed(i_s_tdata[63:32]);
    assign lt    = a < b;
    assign eq    = a == b;
    assign abs_a = a[31] ? 32'(-a) : a;
    assign abs_b = b[31] ? 32'(-b) : b;

    always_comb begin
        cmp          = 1'b0;
        n_side0.res  = '0;
        n_side0.flag = 1'b0;
        n_side0.sel  = SEL_SIMPLE;
        n_side0.neg  = a[31] ^ b[31];
        unique case (op)
            OP_ADD:      n_side0.res = 32'(a + b);
            OP_SUB:      n_side0.res = 32'(a - b);
            OP_MUL:      n_side0.sel = SEL_MUL;
            OP_DIV: begin
                if (b == '0) begin
                    n_side0.flag = 1'b1;  // divide by zero gives zero
                end else begin
                    n_side0.sel = SEL_DIV;
                end
            end
            OP_LT:       cmp = lt;
            OP_GT:       cmp = !lt && !eq;
            OP_LE:       cmp = lt || eq;
            OP_GE:       cmp = !lt;
            OP_EQ:       cmp = eq;
            OP_NE:       cmp = !eq;
            OP_MIN:      n_side0.res = lt ? a : b;
            OP_MAX:      n_side0.res = (!lt && !eq) ? a : b;
            OP_INC:      n_side0.res = 32'(a + 32'sd1);
            OP_DEC:      n_side0.res = 32'(a - 32'sd1);
            OP_TO_INT:   n_side0.res = 32'(a >>> FRAC_BITS);
            OP_FROM_INT: n_side0.res = 32'(a << FRAC_BITS);
        endcase
        if (cmp) begin
            n_side0.res  = ONE;
            n_side0.flag = 1'b1;
        end
    end

    logic               r_vld  [NDIV+1];
    t_side              r_side [NDIV+1];
    logic signed [63:0] r_prod;
    logic [DVD_W-1:0]   r_dvd;
    logic [31:0]        r_dvs;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod    <= 64'(a * b);
            r_dvd     <= DVD_W'({abs_a, {FRAC_BITS{1'b0}}});
            r_dvs     <= abs_b;
        end
    end

    // ---------------- stage 2: multiply rounding toward zero
    t_side                  n_side1;
    logic [FRAC_BITS+31:0]  mul_sum;

    assign mul_sum = r_prod[FRAC_BITS+31:0] + (r_prod[63] ? MUL_BIAS : '0);

    always_comb begin
        n_side1 = r_side[0];
        if (r_side[0].sel == SEL_MUL) begin
            n_side1.res = mul_sum[FRAC_BITS+31:FRAC_BITS];
            n_side1.sel = SEL_SIMPLE;
        end
    end

    // side-band shift line running beside the divider
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side0;
            r_side[1] <= n_side1;
            for (int s = 2; s <= NDIV; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NDIV; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_s_tvalid;
            for (int s = 1; s <= NDIV; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // ---------------- divider stages
    logic [31:0] quo;

    fpa_div_pipe #(
        .NSTG  (NDIV),
        .DVD_W (DVD_W)
    ) u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_dvd (r_dvd),
        .i_dvs (r_dvs),
        .o_quo (quo)
    );

    // ---------------- output register: sign fix and result select
    logic [31:0] n_res;
    logic [31:0] r_res;
    logic        r_flag;
    logic        r_out_vld;

    assign n_res = (r_side[NDIV].sel == SEL_DIV)
                 ? (r_side[NDIV].neg ? 32'(32'd0 - quo) : quo)
                 : r_side[NDIV].res;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res  <= n_res;
            r_flag <= r_side[NDIV].flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[NDIV];
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_res;
    assign o_m_tuser  = r_flag;

    // ---------------- checks
    a_flag_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> (o_m_tdata == ONE || o_m_tdata == '0))
        else $error("flagged result is neither one nor zero");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> r_vld[NDIV] == $past(r_vld[NDIV]))
        else $error("pipe moved during output stall");

endmodule
